@@ sv/rrtt_pkg.sv @@
// shared types and constants of the round-robin task table
`default_nettype none

package rrtt_pkg;

  localparam int ID_W     = 16;
  localparam int CAP_W    = 5;
  localparam int FREE_W   = 5;
  localparam int POS_W    = 8;
  localparam int ADDR_W   = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [POS_W-1:0] POS_RESET = 8'd255;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FREE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET_RD,
    ST_GET_DATA,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t            command;
    logic [ID_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   next_task;
    logic              task_valid;
    logic              success;
    logic [FREE_W-1:0] free_slots;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ID_W-1:0]   wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ sv/rrtt_ram.sv @@
// task slot memory, one write and one registered read per cycle
`default_nettype none

module rrtt_ram #(
  parameter int SLOTS = 16
) (
  input  wire                      clk,
  input  rrtt_pkg::mem_req_t       mem_req,
  output logic [rrtt_pkg::ID_W-1:0] rdata
);

  localparam int AW = $clog2(SLOTS);

  logic [rrtt_pkg::ID_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
    rdata <= mem[mem_req.raddr[AW-1:0]];
  end

endmodule

`default_nettype wire

@@ sv/rrtt_seq.sv @@
// command sequencer: count, position, capacity and the compacting remove scan
`default_nettype none

module rrtt_seq #(
  parameter int SLOTS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          req_valid,
  input  rrtt_pkg::req_t               req,
  output logic                         req_stall,
  input  wire                          cfg_we,
  input  wire [rrtt_pkg::CAP_W-1:0]    cfg_wdata,
  input  wire                          rsp_free,
  output logic                         load,
  output rrtt_pkg::rsp_t               result,
  output rrtt_pkg::mem_req_t           mem_req,
  input  wire [rrtt_pkg::ID_W-1:0]     rdata
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int WW = (CW > rrtt_pkg::CAP_W) ? CW : rrtt_pkg::CAP_W;

  rrtt_pkg::state_t state, state_next;

  logic [CW-1:0]                 count;
  logic [rrtt_pkg::POS_W-1:0]    pos;
  logic [rrtt_pkg::CAP_W-1:0]    capacity;
  logic [rrtt_pkg::ID_W-1:0]     id;
  logic [CW-1:0]                 rd;
  logic [CW-1:0]                 wr;
  logic                          pend;
  logic [rrtt_pkg::ID_W-1:0]     next_task;
  logic                          task_valid;
  logic                          ok;

  logic                          accept;
  logic [WW-1:0]                 eff_cap;
  logic                          room;
  logic [rrtt_pkg::POS_W-1:0]    pos_inc;
  logic [rrtt_pkg::POS_W-1:0]    pos_next;
  logic                          scan_end;
  logic                          keep;
  logic [WW-1:0]                 free_w;

  assign accept = req_valid && !req_stall;

  // capacity above the built depth acts as the depth
  always_comb begin
    if (WW'(capacity) > WW'(SLOTS)) begin
      eff_cap = WW'(SLOTS);
    end else begin
      eff_cap = WW'(capacity);
    end
  end

  assign room     = WW'(count) < eff_cap;
  assign pos_inc  = pos + 1'b1;
  assign pos_next = (pos_inc >= rrtt_pkg::POS_W'(count)) ? '0 : pos_inc;
  assign scan_end = !pend && (rd >= count);
  assign keep     = pend && (rdata != id);
  assign free_w   = (eff_cap > WW'(count)) ? (eff_cap - WW'(count)) : '0;

  always_comb begin
    result.next_task  = next_task;
    result.task_valid = task_valid;
    result.success    = ok;
    result.free_slots = rrtt_pkg::FREE_W'(free_w);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rrtt_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.command)
            rrtt_pkg::CMD_GET: begin
              state_next = (count != '0) ? rrtt_pkg::ST_GET_RD : rrtt_pkg::ST_DONE;
            end
            rrtt_pkg::CMD_REMOVE: begin
              state_next = (count != '0) ? rrtt_pkg::ST_SCAN : rrtt_pkg::ST_DONE;
            end
            default: begin
              state_next = rrtt_pkg::ST_DONE;
            end
          endcase
        end
      end
      rrtt_pkg::ST_GET_RD:   state_next = rrtt_pkg::ST_GET_DATA;
      rrtt_pkg::ST_GET_DATA: state_next = rrtt_pkg::ST_DONE;
      rrtt_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = rrtt_pkg::ST_DONE;
        end
      end
      rrtt_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = rrtt_pkg::ST_IDLE;
        end
      end
      default: state_next = rrtt_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory requests
  always_comb begin
    req_stall     = (state != rrtt_pkg::ST_IDLE);
    load          = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = '0;
    mem_req.raddr = '0;
    case (state)
      rrtt_pkg::ST_IDLE: begin
        if (accept && (req.command == rrtt_pkg::CMD_ADD) && room) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = rrtt_pkg::ADDR_W'(count);
          mem_req.wdata = req.task_id;
        end
      end
      rrtt_pkg::ST_GET_RD: begin
        mem_req.raddr = rrtt_pkg::ADDR_W'(pos);
      end
      rrtt_pkg::ST_SCAN: begin
        // write slot stays behind the read slot, so no forwarding is needed
        mem_req.raddr = rrtt_pkg::ADDR_W'(rd);
        if (keep) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = rrtt_pkg::ADDR_W'(wr);
          mem_req.wdata = rdata;
        end
      end
      rrtt_pkg::ST_DONE: begin
        load = rsp_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rrtt_pkg::ST_IDLE;
      count    <= '0;
      pos      <= rrtt_pkg::POS_RESET;
      capacity <= rrtt_pkg::CAP_RESET;
      pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      case (state)
        rrtt_pkg::ST_IDLE: begin
          if (accept) begin
            id         <= req.task_id;
            next_task  <= '0;
            task_valid <= 1'b0;
            ok         <= 1'b0;
            rd         <= '0;
            wr         <= '0;
            pend       <= 1'b0;
            case (req.command)
              rrtt_pkg::CMD_GET: begin
                if (count != '0) begin
                  pos <= pos_next;
                end
              end
              rrtt_pkg::CMD_ADD: begin
                if (room) begin
                  count <= count + 1'b1;
                  ok    <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        rrtt_pkg::ST_GET_DATA: begin
          next_task  <= rdata;
          task_valid <= 1'b1;
        end
        rrtt_pkg::ST_SCAN: begin
          pend <= (rd < count);
          if (rd < count) begin
            rd <= rd + 1'b1;
          end
          if (keep) begin
            wr <= wr + 1'b1;
          end
          if (pend && !keep) begin
            ok <= 1'b1;
          end
          if (scan_end) begin
            count <= wr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("occupied count above table depth");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == rrtt_pkg::ST_SCAN && mem_req.we) |-> (wr < rd))
    else $error("compaction write overtook the read slot");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == rrtt_pkg::CMD_ADD && room) |=>
      (count == $past(count) + 1'b1))
    else $error("stored add did not grow the count");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == rrtt_pkg::ST_GET_DATA) |-> (rrtt_pkg::POS_W'(count) > pos))
    else $error("get read past the occupied entries");

endmodule

`default_nettype wire

@@ sv/round_robin_task_table.sv @@
// top level of the round-robin task table
`default_nettype none

// Round-robin task table: an ordered list of up to SLOTS task ids in one
// on-chip memory with a registered read. Commands are get (advance the
// round-robin position, wrapping past the last entry, and return that id),
// add (append if below capacity), remove (delete every matching id and close
// the gaps, keeping order) and free (capacity minus count, floored at zero).
// One request is worked at a time; the result sits in an output register so
// the next request can be taken while it waits. Get issues the read, captures
// the data, then holds the result; remove scans the occupied entries: the scan
// moves one entry per cycle through the single read port and writes survivors
// back behind it. The user must write the capacity register through
// cfg_we/cfg_wdata only while the table is idle; the block does not enforce
// this. Values above SLOTS act as SLOTS.
module round_robin_task_table #(
  parameter int SLOTS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  // request channel
  input  wire                       req_valid,
  output logic                      req_stall,
  input  rrtt_pkg::req_t            req,
  // response channel
  output logic                      rsp_valid,
  input  wire                       rsp_stall,
  output rrtt_pkg::rsp_t            rsp,
  // capacity register
  input  wire                       cfg_we,
  input  wire [rrtt_pkg::CAP_W-1:0] cfg_wdata
);

  rrtt_pkg::mem_req_t          mem_req;
  logic [rrtt_pkg::ID_W-1:0]   rdata;
  logic                        rsp_free;
  logic                        load;
  rrtt_pkg::rsp_t              result;

  // output slot is free when empty or being taken this cycle
  assign rsp_free = !rsp_valid || !rsp_stall;

  rrtt_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_free  (rsp_free),
    .load      (load),
    .result    (result),
    .mem_req   (mem_req),
    .rdata     (rdata)
  );

  rrtt_ram #(
    .SLOTS (SLOTS)
  ) u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // response register, holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

@@ test/round_robin_task_table_tb.sv @@
// testbench for the round-robin task table: directed and random requests checked
`timescale 1ns / 1ps

module round_robin_task_table_tb;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  // clock, reset and block ports; the driven ones known from time zero
  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  rrtt_pkg::req_t                 req       = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  rrtt_pkg::rsp_t                 rsp;
  logic                           cfg_we    = 1'b0;
  logic [rrtt_pkg::CAP_W-1:0]     cfg_wdata = '0;

  // predicted table contents, mirrored from the requests the block takes
  logic [rrtt_pkg::ID_W-1:0]      id_table [SLOTS];
  int unsigned                    n_tasks  = 0;
  logic [rrtt_pkg::POS_W-1:0]     rr_pos   = rrtt_pkg::POS_RESET;
  logic [rrtt_pkg::CAP_W-1:0]     cap_reg  = rrtt_pkg::CAP_RESET;

  // predicted responses, oldest first
  rrtt_pkg::rsp_t                 due_responses [$];
  rrtt_pkg::rsp_t                 want_rsp;

  // traffic shaping and bookkeeping
  logic [rrtt_pkg::ID_W-1:0]      id_pool [8];
  bit                             idling_on      = 1'b1;
  bit                             offering       = 1'b0;
  int unsigned                    stall_left     = 0;
  int unsigned                    hold_left      = 0;
  int unsigned                    mismatch_count = 0;
  int unsigned                    checked_count  = 0;
  int unsigned                    cmd_count [4]  = '{0, 0, 0, 0};

  round_robin_task_table #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // applies one request to the predicted table and returns the response it should give
  function automatic rrtt_pkg::rsp_t apply_command(rrtt_pkg::req_t r);
    rrtt_pkg::rsp_t res;
    int unsigned    cap;
    int unsigned    i;
    int unsigned    j;
    res = '0;
    // capacity beyond the built depth acts as the depth
    cap = (cap_reg > SLOTS) ? SLOTS : cap_reg;
    case (r.command)
      rrtt_pkg::CMD_GET: begin
        if (n_tasks != 0) begin
          // 8-bit position wraps 255 -> 0; past the last entry restarts at 0
          rr_pos = rr_pos + 8'd1;
          if (rr_pos >= n_tasks) rr_pos = '0;
          res.next_task  = id_table[IDX_W'(rr_pos)];
          res.task_valid = 1'b1;
        end
      end
      rrtt_pkg::CMD_ADD: begin
        if (n_tasks < cap) begin
          id_table[IDX_W'(n_tasks)] = r.task_id;
          n_tasks++;
          res.success = 1'b1;
        end
      end
      rrtt_pkg::CMD_REMOVE: begin
        // an entry shifted into a freed slot is looked at again
        i = 0;
        while (i < n_tasks) begin
          if (id_table[IDX_W'(i)] == r.task_id) begin
            for (j = i + 1; j < n_tasks; j++) id_table[IDX_W'(j - 1)] = id_table[IDX_W'(j)];
            n_tasks--;
            res.success = 1'b1;
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    // free count saturates at zero when capacity sits below the count
    res.free_slots = (cap > n_tasks) ? rrtt_pkg::FREE_W'(cap - n_tasks) : '0;
    return res;
  endfunction

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [rrtt_pkg::ID_W-1:0] got,
                                 input logic [rrtt_pkg::ID_W-1:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
  endtask

  // offers one request, after a random gap while idling is on, and predicts its response once taken
  task automatic send_request(input rrtt_pkg::req_t r);
    int unsigned gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap != 0 && offering) begin
      req_valid <= 1'b0;
      offering = 1'b0;
    end
    repeat (gap) @(posedge clk);
    req_valid <= 1'b1;
    req       <= r;
    offering = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    due_responses.push_back(apply_command(r));
    cmd_count[r.command]++;
  endtask

  task automatic send_cmd(input rrtt_pkg::cmd_t c, input logic [rrtt_pkg::ID_W-1:0] id);
    rrtt_pkg::req_t r;
    r.command = c;
    r.task_id = id;
    send_request(r);
  endtask

  // drain every outstanding response, then give the block time to settle
  task automatic wait_idle();
    if (offering) begin
      req_valid <= 1'b0;
      offering = 1'b0;
    end
    while (due_responses.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  // capacity write, only while nothing is in flight
  task automatic set_capacity(input logic [rrtt_pkg::CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = value;
    @(posedge clk);
  endtask

  // random request; removes mostly target ids that are in the table
  function automatic rrtt_pkg::req_t random_request(input int unsigned add_pct,
                                                    input int unsigned rm_pct);
    rrtt_pkg::req_t r;
    int unsigned    roll;
    int unsigned    pick;
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    r.task_id = rrtt_pkg::ID_W'($urandom_range(16'hFFFF));
    if (roll < add_pct) begin
      r.command = rrtt_pkg::CMD_ADD;
      if (pick < 7) r.task_id = id_pool[3'($urandom_range(7))];
    end else if (roll < add_pct + rm_pct) begin
      r.command = rrtt_pkg::CMD_REMOVE;
      if (pick < 6 && n_tasks != 0)
        r.task_id = id_table[IDX_W'($urandom_range(n_tasks - 1))];
      else if (pick < 9) r.task_id = id_pool[3'($urandom_range(7))];
    end else if (roll < add_pct + rm_pct + 8) begin
      r.command = rrtt_pkg::CMD_FREE;
    end else begin
      r.command = rrtt_pkg::CMD_GET;
    end
    return r;
  endfunction

  // small id pool so duplicates pile up; keeps the all-zero and all-one ids
  task automatic refresh_pool();
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < 8; k++) id_pool[k] = rrtt_pkg::ID_W'($urandom_range(16'hFFFF));
  endtask

  task automatic run_phase(input logic [rrtt_pkg::CAP_W-1:0] cap, input int unsigned count,
                           input int unsigned add_pct, input int unsigned rm_pct);
    wait_idle();
    set_capacity(cap);
    refresh_pool();
    repeat (count) send_request(random_request(add_pct, rm_pct));
  endtask

  // get, free and remove on the empty table after reset
  task automatic test_empty_table();
    send_cmd(rrtt_pkg::CMD_GET, 16'hFFFF);
    send_cmd(rrtt_pkg::CMD_FREE, 16'hFFFF);
    send_cmd(rrtt_pkg::CMD_REMOVE, 16'hFFFF);
  endtask

  // first get after reset picks entry 0, then rotation wraps
  task automatic test_add_and_rotate();
    send_cmd(rrtt_pkg::CMD_ADD, 16'h0000);
    send_cmd(rrtt_pkg::CMD_ADD, 16'hFFFF);
    send_cmd(rrtt_pkg::CMD_ADD, 16'h1234);
    repeat (4) send_cmd(rrtt_pkg::CMD_GET, 16'h0000);
  endtask

  // adjacent duplicates removed together, position left past the count
  task automatic test_remove_matches();
    send_cmd(rrtt_pkg::CMD_ADD, 16'h1234);
    send_cmd(rrtt_pkg::CMD_ADD, 16'h0001);
    repeat (3) send_cmd(rrtt_pkg::CMD_GET, 16'h0000);
    send_cmd(rrtt_pkg::CMD_REMOVE, 16'h1234);
    send_cmd(rrtt_pkg::CMD_GET, 16'h0000);
    send_cmd(rrtt_pkg::CMD_REMOVE, 16'h7777);
  endtask

  // capacity zero, capacity beyond depth, capacity below the count
  task automatic test_capacity_corners();
    wait_idle();
    set_capacity(5'd0);
    send_cmd(rrtt_pkg::CMD_ADD, 16'h00FF);
    send_cmd(rrtt_pkg::CMD_FREE, 16'h0000);
    wait_idle();
    set_capacity(5'd31);
    send_cmd(rrtt_pkg::CMD_FREE, 16'h0000);
    wait_idle();
    set_capacity(5'd1);
    send_cmd(rrtt_pkg::CMD_ADD, 16'hFF00);
    send_cmd(rrtt_pkg::CMD_FREE, 16'h0000);
  endtask

  // random traffic across capacity settings, from filling up to draining
  task automatic test_random_traffic();
    run_phase(5'd16, 80, 60, 15);
    run_phase(5'd4, 50, 30, 25);
    run_phase(5'd31, 60, 45, 25);
    run_phase(5'd1, 30, 35, 30);
    run_phase(5'd0, 20, 40, 30);
    run_phase(5'($urandom_range(2, 15)), 50, 40, 30);
    run_phase(5'd16, 60, 25, 45);
  endtask

  // a stretch with no idling on either side
  task automatic test_back_to_back();
    idling_on = 1'b0;
    run_phase(5'd16, 40, 45, 30);
    idling_on = 1'b1;
  endtask

  // receiver holds off long enough that the block must stall new requests
  task automatic test_backpressure();
    wait_idle();
    set_capacity(5'd16);
    idling_on = 1'b0;
    hold_left <= 80;
    repeat (14) send_request(random_request(50, 25));
    idling_on = 1'b1;
  endtask

  // response stall: random gaps, or a long hold when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
      if (idling_on) stall_left <= pick_gap();
    end
  end

  // every taken response is matched against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_responses.size() == 0) begin
        report_mismatch("response with no request outstanding", rsp.next_task, '0);
      end else begin
        want_rsp = due_responses.pop_front();
        checked_count++;
        if (rsp.next_task !== want_rsp.next_task)
          report_mismatch("next_task", rsp.next_task, want_rsp.next_task);
        if (rsp.task_valid !== want_rsp.task_valid)
          report_mismatch("task_valid", rrtt_pkg::ID_W'(rsp.task_valid),
                          rrtt_pkg::ID_W'(want_rsp.task_valid));
        if (rsp.success !== want_rsp.success)
          report_mismatch("success", rrtt_pkg::ID_W'(rsp.success),
                          rrtt_pkg::ID_W'(want_rsp.success));
        if (rsp.free_slots !== want_rsp.free_slots)
          report_mismatch("free_slots", rrtt_pkg::ID_W'(rsp.free_slots),
                          rrtt_pkg::ID_W'(want_rsp.free_slots));
      end
    end
  end

  // hard limit on the run
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_add_and_rotate();
    test_remove_matches();
    test_capacity_corners();
    test_random_traffic();
    test_back_to_back();
    test_backpressure();
    wait_idle();

    if (due_responses.size() != 0)
      report_mismatch("responses never seen", rrtt_pkg::ID_W'(due_responses.size()), '0);
    $display("covered %0d get, %0d add, %0d remove, %0d free requests, capacities 0 to 31",
             cmd_count[rrtt_pkg::CMD_GET], cmd_count[rrtt_pkg::CMD_ADD],
             cmd_count[rrtt_pkg::CMD_REMOVE], cmd_count[rrtt_pkg::CMD_FREE]);
    $display("%0d responses checked, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rrtt_pkg.sv
sv/rrtt_ram.sv
sv/rrtt_seq.sv
sv/round_robin_task_table.sv
test/round_robin_task_table_tb.sv
